FILE: hw/rtl/bbt_pkg.sv
// ----------------------------------------------------------------------------
// bbt_pkg
// Shared types, constants and the knot table of the blackbody colour block.
// ----------------------------------------------------------------------------
package bbt_pkg;

	// knot and channel formats
	typedef logic [16:0] knot_t;     // unsigned Q1.16
	typedef knot_t [3:0] knot4_t;    // four consecutive knots of one channel
	typedef logic [16:0] chan_t;     // spline result, unsigned Q1.16
	typedef logic [18:0] pix_t;      // normalised output, unsigned Q3.16

	// temperature range and segment split
	localparam logic [15:0] TEMP_MIN   = 16'd1000;
	localparam logic [15:0] TEMP_MAX   = 16'd10000;
	localparam logic [13:0] TEMP_SPAN  = 14'd9000;
	localparam logic [13:0] SEG_RECIP  = 14'd8389;   // ceil(2^22 / 500)
	localparam logic [8:0]  SEG_SPAN   = 9'd500;

	// spline scaling: value = n / 250e6, split as (n >> 7) / 5^9
	localparam logic [31:0] DIV_RECIP  = 32'd2305843009; // floor(2^52 / 5^9)
	localparam logic [20:0] SPLINE_DIV = 21'd1953125;

	// output saturation and pipeline length ahead of the output register
	localparam pix_t        OUT_SAT    = 19'd327679;
	localparam int          PIPE_DEPTH = 34;

	// knot table, {red, green, blue}
	function automatic logic [50:0] knot_row(input logic [4:0] idx);
		logic [50:0] row;
		case (idx)
			5'd0:    row = {17'd65536, 17'd1802,  17'd0};
			5'd1:    row = {17'd65536, 17'd1802,  17'd0};
			5'd2:    row = {17'd65536, 17'd9808,  17'd0};
			5'd3:    row = {17'd65536, 17'd16819, 17'd531};
			5'd4:    row = {17'd65536, 17'd24382, 17'd4420};
			5'd5:    row = {17'd65536, 17'd31243, 17'd10066};
			5'd6:    row = {17'd65536, 17'd37380, 17'd16987};
			5'd7:    row = {17'd65536, 17'd42826, 17'd24717};
			5'd8:    row = {17'd65536, 17'd47637, 17'd32873};
			5'd9:    row = {17'd65536, 17'd51875, 17'd41160};
			5'd10:   row = {17'd65536, 17'd55605, 17'd49364};
			5'd11:   row = {17'd65536, 17'd58889, 17'd57338};
			5'd12:   row = {17'd65536, 17'd61785, 17'd64988};
			5'd13:   row = {17'd59438, 17'd58357, 17'd65536};
			5'd14:   row = {17'd54280, 17'd55171, 17'd65536};
			5'd15:   row = {17'd50187, 17'd52553, 17'd65536};
			5'd16:   row = {17'd46875, 17'd50370, 17'd65536};
			5'd17:   row = {17'd44150, 17'd48524, 17'd65536};
			5'd18:   row = {17'd41877, 17'd46947, 17'd65536};
			5'd19:   row = {17'd39956, 17'd45586, 17'd65536};
			5'd20:   row = {17'd39956, 17'd45586, 17'd65536};
			5'd21:   row = {17'd39956, 17'd45586, 17'd65536};
			default: row = {17'd39956, 17'd45586, 17'd65536};
		endcase
		return row;
	endfunction

endpackage

FILE: hw/rtl/bbt_seg.sv
// ----------------------------------------------------------------------------
// bbt_seg
// Clamps the temperature, splits it into segment and offset, fetches knots.
// ----------------------------------------------------------------------------
module bbt_seg (
	input  logic              clk,
	input  logic              en,
	input  logic [15:0]       temp,
	output logic [8:0]        r,
	output bbt_pkg::knot4_t   knots_r,
	output bbt_pkg::knot4_t   knots_g,
	output bbt_pkg::knot4_t   knots_b
);

	logic [13:0] tc_d;
	logic [15:0] tsub;
	logic [13:0] tc_s1;
	logic [27:0] prod_s2;
	logic [13:0] tc_s2;
	logic [4:0]  seg_d;
	logic [13:0] seg_mul;
	logic [8:0]  r_d;
	logic [4:0]  seg_s3;
	logic [8:0]  r_s3;
	logic [50:0] row [0:3];
	bbt_pkg::knot4_t kr_s4, kg_s4, kb_s4;
	logic [8:0]  r_s4;

	// clamp to range and remove the base temperature
	always_comb begin
		tsub = temp - bbt_pkg::TEMP_MIN;
		if (temp < bbt_pkg::TEMP_MIN)
			tc_d = '0;
		else if (temp > bbt_pkg::TEMP_MAX)
			tc_d = bbt_pkg::TEMP_SPAN;
		else
			tc_d = tsub[13:0];
	end

	// segment index from reciprocal, offset by subtraction
	always_comb begin
		seg_d   = prod_s2[26:22];
		seg_mul = 14'(seg_d * bbt_pkg::SEG_SPAN);
		r_d     = 9'(tc_s2 - seg_mul);
	end

	// four table rows per segment
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			row[j] = bbt_pkg::knot_row(5'(seg_s3 + 5'(j)));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tc_s1   <= tc_d;
			prod_s2 <= 28'(tc_s1 * bbt_pkg::SEG_RECIP);
			tc_s2   <= tc_s1;
			seg_s3  <= seg_d;
			r_s3    <= r_d;
			for (int j = 0; j < 4; j++) begin
				kr_s4[j] <= row[j][50:34];
				kg_s4[j] <= row[j][33:17];
				kb_s4[j] <= row[j][16:0];
			end
			r_s4 <= r_s3;
		end
	end

	assign r       = r_s4;
	assign knots_r = kr_s4;
	assign knots_g = kg_s4;
	assign knots_b = kb_s4;

endmodule

FILE: hw/rtl/bbt_spline.sv
// ----------------------------------------------------------------------------
// bbt_spline
// Catmull-Rom segment evaluation of one channel by Horner steps, rounded
// to Q1.16 and clamped at zero.
// ----------------------------------------------------------------------------
module bbt_spline (
	input  logic            clk,
	input  logic            en,
	input  bbt_pkg::knot4_t k,
	input  logic [8:0]      r,
	output bbt_pkg::chan_t  v
);

	logic signed [21:0] k0, k1, k2, k3;
	logic signed [21:0] a_s1, b_s1, c_s1, c_s2, c_s2n;
	logic [17:0]        d_s1, d_s2, d_s3;
	logic [8:0]         r_s1, r_s2, r_s3;
	logic signed [31:0] h1_d, h1_s2;
	logic signed [39:0] h2_d, h2_s3;
	logic signed [49:0] n_d, n_s4, nr;
	logic [40:0]        m_s5, m_s6, m_s7;
	logic               pos_s5, pos_s6, pos_s7;
	logic [60:0]        prod_s6;
	logic [17:0]        q0_d, q0_s7;
	logic [40:0]        qm_s7;
	logic [40:0]        rem;
	logic [17:0]        v_d;
	bbt_pkg::chan_t     v_s8;

	assign k0 = $signed({5'b0, k[0]});
	assign k1 = $signed({5'b0, k[1]});
	assign k2 = $signed({5'b0, k[2]});
	assign k3 = $signed({5'b0, k[3]});

	// horner steps: ((a r + 500 b) r + 250000 c) r + 125e6 d
	assign c_s2n = c_s2;
	assign h1_d = 32'(a_s1) * 32'($signed({1'b0, r_s1})) + 32'(b_s1) * 32'sd500;
	assign h2_d = 40'(h1_s2) * 40'($signed({1'b0, r_s2})) + 40'(c_s2n) * 40'sd250000;
	assign n_d  = 50'(h2_s3) * 50'($signed({1'b0, r_s3}))
		+ 50'($signed({1'b0, d_s3})) * 50'sd125000000;

	// round half up, drop the power of two of the divisor
	assign nr   = n_s4 + 50'sd125000000;

	// quotient estimate and one-step correction
	assign q0_d = prod_s6[57:40];
	assign rem  = m_s7 - qm_s7;
	always_comb begin
		if (!pos_s7)
			v_d = '0;
		else if (rem >= 41'(bbt_pkg::SPLINE_DIV))
			v_d = 18'(q0_s7 + 18'd1);
		else
			v_d = q0_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= -k0 + 22'sd3 * k1 - 22'sd3 * k2 + k3;
			b_s1    <= 22'sd2 * k0 - 22'sd5 * k1 + 22'sd4 * k2 - k3;
			c_s1    <= k2 - k0;
			d_s1    <= {k[1], 1'b0};
			r_s1    <= r;
			h1_s2   <= h1_d;
			c_s2    <= c_s1;
			d_s2    <= d_s1;
			r_s2    <= r_s1;
			h2_s3   <= h2_d;
			d_s3    <= d_s2;
			r_s3    <= r_s2;
			n_s4    <= n_d;
			pos_s5  <= (n_s4 > 50'sd0);
			m_s5    <= nr[47:7];
			prod_s6 <= 61'(m_s5[40:12] * bbt_pkg::DIV_RECIP);
			m_s6    <= m_s5;
			pos_s6  <= pos_s5;
			q0_s7   <= q0_d;
			qm_s7   <= 41'(q0_d * bbt_pkg::SPLINE_DIV);
			m_s7    <= m_s6;
			pos_s7  <= pos_s6;
			v_s8    <= v_d[16:0];
		end
	end

	assign v = v_s8;

endmodule

FILE: hw/rtl/bbt_div.sv
// ----------------------------------------------------------------------------
// bbt_div
// Pipelined restoring divider, one quotient bit per stage, with overflow
// and zero-divisor flags and saturation of the result.
// ----------------------------------------------------------------------------
module bbt_div (
	input  logic          clk,
	input  logic          en,
	input  logic [45:0]   num,
	input  logic [29:0]   den,
	output bbt_pkg::pix_t q
);

	logic [45:0] rem_s  [0:19];
	logic [29:0] den_s  [0:19];
	logic [18:0] q_s    [0:19];
	logic        ovf_s  [0:19];
	logic        zero_s [0:19];

	// first stage: quotient would not fit in 19 bits, or divisor is zero
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num;
			den_s[0]  <= den;
			q_s[0]    <= '0;
			ovf_s[0]  <= (30'(num[45:19]) >= den);
			zero_s[0] <= (den == '0);
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 1; k <= 19; k++) begin : g_bit
		localparam int B = 19 - k;
		logic [48:0] dsh;
		logic [48:0] diff;
		logic        take;

		assign dsh  = 49'(den_s[k-1]) << B;
		assign diff = 49'(rem_s[k-1]) - dsh;
		assign take = (49'(rem_s[k-1]) >= dsh);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? diff[45:0] : rem_s[k-1];
				q_s[k]    <= take ? (q_s[k-1] | (19'd1 << B)) : q_s[k-1];
				den_s[k]  <= den_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				zero_s[k] <= zero_s[k-1];
			end
		end
	end

	// saturate, zero divisor gives zero
	always_comb begin
		if (zero_s[19])
			q = '0;
		else if (ovf_s[19] || (q_s[19] > bbt_pkg::OUT_SAT))
			q = bbt_pkg::OUT_SAT;
		else
			q = q_s[19];
	end

endmodule

FILE: hw/rtl/blackbody_temperature_to_rgb.sv
// ----------------------------------------------------------------------------
// blackbody_temperature_to_rgb
// Colour temperature in kelvin to a unit-luminance RGB triple.
// ----------------------------------------------------------------------------
// Takes one 16-bit temperature word per cycle unless stalled and returns
// one RGB word per temperature, in order. The temperature is
// clamped to 1000..10000 K and selects a 500 K Catmull-Rom segment of a
// fixed knot table; each channel is rounded to Q1.16, clamped at zero, then
// divided by its Rec.709 luma and saturated to Q3.16 (max 327679). The
// pipeline is the four-stage segment and knot fetch, the eight-stage
// spline pipeline, two luma stages, the 20-stage output divider and the
// output register; throughput is one word per cycle unless stalled. The
// whole pipeline holds when the output word is not taken.
// ----------------------------------------------------------------------------
module blackbody_temperature_to_rgb (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] temperature_kelvin
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [18:0] red, [37:19] green, [56:38] blue, zero pad
);

	logic                   en;
	logic [bbt_pkg::PIPE_DEPTH-1:0] vld_s;
	logic                   out_vld_q;
	logic [8:0]             r;
	bbt_pkg::knot4_t        kn_r, kn_g, kn_b;
	bbt_pkg::chan_t         vr, vg, vb;
	logic [29:0]            lu_s1, den_s2;
	logic [29:0]            xr_s1, xg_s1, xb_s1;
	logic [45:0]            nr_s2, ng_s2, nb_s2;
	bbt_pkg::pix_t          qr, qg, qb;
	bbt_pkg::pix_t          red_q, green_q, blue_q;

	// global advance: move when the output register is free or being drained
	assign en       = ~out_vld_q | m_tready;
	assign s_tready = en;

	// valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s     <= {vld_s[bbt_pkg::PIPE_DEPTH-2:0], s_tvalid};
			out_vld_q <= vld_s[bbt_pkg::PIPE_DEPTH-1];
		end
	end

	// segment and knot fetch
	bbt_seg u_seg (
		.clk     (clk),
		.en      (en),
		.temp    (s_tdata),
		.r       (r),
		.knots_r (kn_r),
		.knots_g (kn_g),
		.knots_b (kn_b)
	);

	// spline per channel
	bbt_spline u_spl_r (.clk(clk), .en(en), .k(kn_r), .r(r), .v(vr));
	bbt_spline u_spl_g (.clk(clk), .en(en), .k(kn_g), .r(r), .v(vg));
	bbt_spline u_spl_b (.clk(clk), .en(en), .k(kn_b), .r(r), .v(vb));

	// luma and scaled numerators
	always_ff @(posedge clk) begin
		if (en) begin
			lu_s1  <= 30'(vr * 13'd2126) + 30'(vg * 13'd7152) + 30'(vb * 13'd722);
			xr_s1  <= 30'(vr * 14'd10000);
			xg_s1  <= 30'(vg * 14'd10000);
			xb_s1  <= 30'(vb * 14'd10000);
			nr_s2  <= {xr_s1, 16'b0} + 46'(lu_s1 >> 1);
			ng_s2  <= {xg_s1, 16'b0} + 46'(lu_s1 >> 1);
			nb_s2  <= {xb_s1, 16'b0} + 46'(lu_s1 >> 1);
			den_s2 <= lu_s1;
		end
	end

	// luminance normalisation
	bbt_div u_div_r (.clk(clk), .en(en), .num(nr_s2), .den(den_s2), .q(qr));
	bbt_div u_div_g (.clk(clk), .en(en), .num(ng_s2), .den(den_s2), .q(qg));
	bbt_div u_div_b (.clk(clk), .en(en), .num(nb_s2), .den(den_s2), .q(qb));

	// output word register
	always_ff @(posedge clk) begin
		if (en) begin
			red_q   <= qr;
			green_q <= qg;
			blue_q  <= qb;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'b0, blue_q, green_q, red_q};

endmodule
